### rtl/mvm_pkg.sv
`timescale 1ns / 1ps

package mvm_pkg;

   // Sizes of the vector store and of the data path
   localparam int MAX_COLS  = 4096;
   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 8;
   localparam int ADDR_W    = $clog2(MAX_COLS);
   localparam int COL_W     = 13;
   localparam int ROW_W     = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = 48;

   // Request kinds carried on req_tuser
   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_WEIGHT = 1'b1
   } mvm_cmd_type;

   // Register indexes of the configuration port
   typedef enum logic {
      CSR_N_COLS = 1'b0,
      CSR_N_ROWS = 1'b1
   } mvm_csr_type;

   // Control that travels beside each weight through the MAC pipeline
   typedef struct packed {
      logic             valid;
      logic             first_col;
      logic             last_col;
      logic [ROW_W-1:0] row_index;
      logic             last_row;
   } mvm_ctl_type;

endpackage

### rtl/mvm_ram.sv
`timescale 1ns / 1ps

module mvm_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mvm_sequencer.sv
`timescale 1ns / 1ps

module mvm_sequencer
   import mvm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [ROW_W-1:0]   csr_data,
   // request side
   input  logic               req_valid,
   input  logic               req_cmd,
   input  logic [ADDR_W-1:0]  req_index,
   input  logic [DATA_W-1:0]  req_value,
   input  logic               advance,
   output logic               req_ready,
   // vector store access
   output logic               ram_wr_en,
   output logic [ADDR_W-1:0]  ram_wr_addr,
   output logic [DATA_W-1:0]  ram_wr_data,
   output logic               ram_rd_en,
   output logic [ADDR_W-1:0]  ram_rd_addr,
   // first pipeline stage, aligned with the read data
   output mvm_ctl_type        ctl_out,
   output logic [DATA_W-1:0]  weight_out
);

   localparam logic [COL_W-1:0] MaxColsC = COL_W'(MAX_COLS);

   logic [COL_W-1:0]  n_cols_ff;
   logic [ROW_W-1:0]  n_rows_ff;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   mvm_ctl_type       ctl_ff, ctl_in;
   logic [DATA_W-1:0] weight_ff;
   logic [COL_W-1:0]  cols_eff;
   logic [ROW_W:0]    rows_eff;
   logic              accept;
   logic              is_weight;
   logic              last_col;
   logic              last_row;

   assign csr_ready = 1'b1;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign is_weight = (req_cmd == CMD_WEIGHT);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_cols_ff <= COL_W'(1);
         n_rows_ff <= ROW_W'(1);
      end else if (csr_valid) begin
         if (csr_index == CSR_N_COLS) begin
            n_cols_ff <= csr_data[COL_W-1:0];
         end
         if (csr_index == CSR_N_ROWS) begin
            n_rows_ff <= csr_data;
         end
      end
   end

   // Clamp the lengths into their legal ranges
   always_comb begin
      if (n_cols_ff == '0) begin
         cols_eff = COL_W'(1);
      end else if (n_cols_ff > MaxColsC) begin
         cols_eff = MaxColsC;
      end else begin
         cols_eff = n_cols_ff;
      end
      rows_eff = (n_rows_ff == '0) ? (ROW_W+1)'(1) : {1'b0, n_rows_ff};
   end

   assign last_col = ((COL_W'(col_ff) + COL_W'(1)) >= cols_eff);
   assign last_row = (({1'b0, row_ff} + (ROW_W+1)'(1)) >= rows_eff);

   // Advance the column and row counters; a load restarts the product
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!is_weight) begin
            col_in = '0;
            row_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end
   end

   always_comb begin
      ctl_in.valid     = accept && is_weight;
      ctl_in.first_col = (col_ff == '0);
      ctl_in.last_col  = last_col;
      ctl_in.row_index = row_ff;
      ctl_in.last_row  = last_row;
   end

   // Counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // First pipeline stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         ctl_ff.first_col <= ctl_in.first_col;
         ctl_ff.last_col  <= ctl_in.last_col;
         ctl_ff.row_index <= ctl_in.row_index;
         ctl_ff.last_row  <= ctl_in.last_row;
         weight_ff        <= req_value;
      end
   end

   // Loads write the store, every advancing cycle reads the current column
   assign ram_wr_en   = accept && !is_weight;
   assign ram_wr_addr = req_index;
   assign ram_wr_data = req_value;
   assign ram_rd_en   = advance;
   assign ram_rd_addr = col_ff;

   assign ctl_out    = ctl_ff;
   assign weight_out = weight_ff;

endmodule

### rtl/mvm_mac.sv
`timescale 1ns / 1ps

module mvm_mac
   import mvm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mvm_ctl_type       ctl_in,
   input  logic [DATA_W-1:0] weight_in,
   input  logic [DATA_W-1:0] vec_in,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_value,
   output logic [ROW_W-1:0]  rsp_row,
   output logic              rsp_last,
   output logic              rsp_sat
);

   localparam int HiW = ACC_W - FRAC_BITS - DATA_W + 1;

   mvm_ctl_type              ctl2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     res_valid_ff;
   logic [ROW_W-1:0]         res_row_ff;
   logic                     res_last_ff;
   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        rsp_value_ff, value_in;
   logic [ROW_W-1:0]         rsp_row_ff;
   logic                     rsp_last_ff;
   logic                     rsp_sat_ff, sat_in;
   logic signed [ACC_W-1:0]  shifted;
   logic [HiW-1:0]           upper;

   // Whole pipeline moves unless a result is waiting on a stalled consumer
   assign advance = !rsp_valid_ff || rsp_ready;

   // Multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl2_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         ctl2_ff.first_col <= ctl_in.first_col;
         ctl2_ff.last_col  <= ctl_in.last_col;
         ctl2_ff.row_index <= ctl_in.row_index;
         ctl2_ff.last_row  <= ctl_in.last_row;
         prod_ff           <= signed'(weight_in) * signed'(vec_in);
      end
   end

   // Accumulate stage; the first column of a row starts from zero
   assign acc_in = (ctl2_ff.first_col ? '0 : acc_ff) + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         if (ctl2_ff.valid) begin
            acc_ff <= acc_in;
         end
         res_valid_ff <= ctl2_ff.valid && ctl2_ff.last_col;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_row_ff  <= ctl2_ff.row_index;
         res_last_ff <= ctl2_ff.last_row;
      end
   end

   // Scale down and clip to the data width
   assign shifted = acc_ff >>> FRAC_BITS;
   assign upper   = shifted[ACC_W-FRAC_BITS-1:DATA_W-1];

   always_comb begin
      sat_in   = !((&upper) || !(|upper));
      value_in = shifted[DATA_W-1:0];
      if (sat_in) begin
         value_in = shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= value_in;
         rsp_row_ff   <= res_row_ff;
         rsp_last_ff  <= res_last_ff;
         rsp_sat_ff   <= sat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_sat   = rsp_sat_ff;

endmodule

### rtl/matrix_vector_multiply.sv
// Channel    Direction  Handshake              Contents
// req_       in         req_tvalid/tready      tdata: vec_index, value; tuser: cmd
// rsp_       out        rsp_tvalid/tready      tdata: out_value, row_index; tlast; tuser
// csr_       in         csr_valid/csr_ready    csr_index selects n_cols or n_rows
//
// One request per cycle, loads and weights alike, unless a waiting result
// stalls the pipeline; after its last weight is taken, a row result passes
// the first stage and the multiply, accumulate and output registers. Rate is
// set by one store read per weight and one multiply-accumulate per cycle in the MAC.
// Reset is synchronous; the vector store is not cleared and must be loaded.
// While a result waits with rsp_tready low, the whole pipeline holds and
// req_tready drops; csr_ready is always high.
`timescale 1ns / 1ps

module matrix_vector_multiply
   import mvm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [11:0] vec_index, [27:12] value, [31:28] zero
   input  logic        req_tuser,   // [0] cmd
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] out_value, [31:16] row_index
   output logic        rsp_tlast,   // last_row
   output logic        rsp_tuser    // [0] saturated
);

   logic               advance;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [DATA_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0]  ram_rd_data;
   mvm_ctl_type        ctl1;
   logic [DATA_W-1:0]  weight1;
   logic [DATA_W-1:0]  rsp_value;
   logic [ROW_W-1:0]   rsp_row;

   mvm_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_tvalid),
      .req_cmd     (req_tuser),
      .req_index   (req_tdata[ADDR_W-1:0]),
      .req_value   (req_tdata[ADDR_W+DATA_W-1:ADDR_W]),
      .advance     (advance),
      .req_ready   (req_tready),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ctl_out     (ctl1),
      .weight_out  (weight1)
   );

   mvm_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mvm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl1),
      .weight_in (weight1),
      .vec_in    (ram_rd_data),
      .advance   (advance),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_value),
      .rsp_row   (rsp_row),
      .rsp_last  (rsp_tlast),
      .rsp_sat   (rsp_tuser)
   );

   assign rsp_tdata = {rsp_row, rsp_value};

endmodule

### rtl/mvm_checker.sv
`timescale 1ns / 1ps

module mvm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Hold a result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // Clipped results sit at one of the two limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] == 16'h7FFF ||
                                  rsp_tdata[15:0] == 16'h8000)
      else $error("saturated flag without a limit value");

   // Drop request ready only behind a stalled result
   a_stall_cause: assert property (@(posedge clock)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request side stalled without a waiting result");

   // Reset leaves no result behind
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
